// ===== design/olist_pkg.sv =====
// Shared types, sizes and codes for the ordered list block.
package olist_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  localparam int OPCODE_W   = 2;
  localparam int POS_W      = 5;
  localparam int ITEM_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int FOUND_W    = 4;
  localparam int COUNT_W    = 5;

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int VAL_W  = (DATA_WIDTH < ITEM_W) ? DATA_WIDTH : ITEM_W;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int FX_W   = (IDX_W > FOUND_W) ? IDX_W : FOUND_W;
  localparam int CX_W   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_FIND   = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT_UP,
    S_SHIFT_DOWN,
    S_SEARCH,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    RS_AT,
    RS_BELOW,
    RS_ABOVE
  } rsel_t;

  typedef enum logic [1:0] {
    WS_APPEND,
    WS_SHIFT,
    WS_PLACE
  } wsel_t;

  typedef struct packed {
    logic    load_cmd;
    logic    j_load_used;
    logic    j_load_pos;
    logic    j_load_zero;
    logic    j_inc;
    logic    j_dec;
    logic    wr_en;
    wsel_t   wsel;
    rsel_t   rsel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_status;
    status_t status;
    logic    set_found;
    logic    load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    pos_above_used;
    logic    pos_not_below_used;
    logic    full;
    logic    j_above_pos;
    logic    next_below_used;
    logic    j_below_used;
    logic    hit;
    logic    out_free;
  } dp_stat_t;

endpackage

// ===== design/ordered_list_insert_delete_find.sv =====
// Top level of the fixed-capacity ordered list with append, insert, delete and find.
//
// Input beats carry one command: opcode, position and item_value. A beat is
// taken when in_valid is high and in_stall is low. The block works on one
// command at a time and holds in_stall high from the cycle after a beat is
// taken until its result has been loaded into the output register.
// Every command yields one output beat with status, found_position and
// entry_count, taken when out_valid is high and out_stall is low.
// An append or a rejected command goes from decode straight to the finish
// state. An insert at position p moves the entries from p upward one place
// and then writes the item at p, a delete at p moves the entries above p
// down one place, and a find compares the entries from index 0 until one
// matches or the used entries run out. The length of a command is set by the
// single entry read port, which moves or compares one entry per cycle, and
// the next beat can be taken in the cycle after the result is loaded.
// While the receiver stalls, the result stays in the output register and the
// next command can still be taken and worked on; it then waits before its
// result is loaded. Synchronous reset empties the list and drops any result.
module ordered_list_insert_delete_find (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [olist_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [olist_pkg::POS_W-1:0]    in_position,
  input  logic [olist_pkg::ITEM_W-1:0]   in_item_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [olist_pkg::STATUS_W-1:0] out_status,
  output logic [olist_pkg::FOUND_W-1:0]  out_found_position,
  output logic [olist_pkg::COUNT_W-1:0]  out_entry_count
);
  import olist_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  olist_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  olist_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_opcode          (in_opcode),
    .in_position        (in_position),
    .in_item_value      (in_item_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_entry_count    (out_entry_count),
    .cmd                (cmd),
    .stat               (stat)
  );

endmodule

// ===== design/olist_ctrl.sv =====
// Controller state machine that sequences each list command.
module olist_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  olist_pkg::dp_stat_t  stat,
  output olist_pkg::ctrl_cmd_t cmd
);
  import olist_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.rsel  = RS_AT;
    cmd.wsel  = WS_SHIFT;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_cmd = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FINISH;
        case (stat.op)
          OP_APPEND: begin
            if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wsel    = WS_APPEND;
              cmd.cnt_inc = 1'b1;
            end
          end
          OP_INSERT: begin
            if (stat.pos_above_used) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_RANGE;
            end else if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else begin
              cmd.j_load_used = 1'b1;
              state_nxt       = S_SHIFT_UP;
            end
          end
          OP_DELETE: begin
            if (stat.pos_not_below_used) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_RANGE;
            end else begin
              cmd.j_load_pos = 1'b1;
              state_nxt      = S_SHIFT_DOWN;
            end
          end
          OP_FIND: begin
            cmd.set_status  = 1'b1;
            cmd.status      = ST_MISSING;
            cmd.j_load_zero = 1'b1;
            state_nxt       = S_SEARCH;
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_SHIFT_UP: begin
        cmd.rsel = RS_BELOW;
        if (stat.j_above_pos) begin
          cmd.wr_en = 1'b1;
          cmd.wsel  = WS_SHIFT;
          cmd.j_dec = 1'b1;
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wsel    = WS_PLACE;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_FINISH;
        end
      end
      S_SHIFT_DOWN: begin
        cmd.rsel = RS_ABOVE;
        if (stat.next_below_used) begin
          cmd.wr_en = 1'b1;
          cmd.wsel  = WS_SHIFT;
          cmd.j_inc = 1'b1;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_FINISH;
        end
      end
      S_SEARCH: begin
        cmd.rsel = RS_AT;
        if (stat.j_below_used) begin
          if (stat.hit) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_OK;
            cmd.set_found  = 1'b1;
            state_nxt      = S_FINISH;
          end else begin
            cmd.j_inc = 1'b1;
          end
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/olist_dp.sv =====
// Datapath with the entry registers, entry count, walk index and result register.
module olist_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [olist_pkg::OPCODE_W-1:0]      in_opcode,
  input  logic [olist_pkg::POS_W-1:0]         in_position,
  input  logic [olist_pkg::ITEM_W-1:0]        in_item_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [olist_pkg::STATUS_W-1:0]      out_status,
  output logic [olist_pkg::FOUND_W-1:0]       out_found_position,
  output logic [olist_pkg::COUNT_W-1:0]       out_entry_count,
  input  olist_pkg::ctrl_cmd_t                cmd,
  output olist_pkg::dp_stat_t                 stat
);
  import olist_pkg::*;

  logic [VAL_W-1:0]    ent_r [CAPACITY];
  opcode_t             op_r;
  logic [POS_W-1:0]    pos_r;
  logic [VAL_W-1:0]    val_r;
  logic [CNT_W-1:0]    used_r;
  logic [CNT_W-1:0]    j_r;
  status_t             status_r;
  logic [IDX_W-1:0]    found_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [FOUND_W-1:0]  out_found_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic [CMP_W-1:0]    pos_x;
  logic [CMP_W-1:0]    used_x;
  logic [CMP_W-1:0]    j_x;
  logic [CNT_W-1:0]    j_plus;
  logic [CNT_W-1:0]    j_minus;
  logic [CNT_W-1:0]    rd_idx;
  logic [VAL_W-1:0]    rd_data;
  logic [CNT_W-1:0]    wr_idx;
  logic [VAL_W-1:0]    wr_data;

  assign pos_x   = CMP_W'(pos_r);
  assign used_x  = CMP_W'(used_r);
  assign j_x     = CMP_W'(j_r);
  assign j_plus  = j_r + CNT_W'(1);
  assign j_minus = j_r - CNT_W'(1);

  always_comb begin
    case (cmd.rsel)
      RS_BELOW: rd_idx = j_minus;
      RS_ABOVE: rd_idx = j_plus;
      default:  rd_idx = j_r;
    endcase
  end

  assign rd_data = ent_r[rd_idx[IDX_W-1:0]];

  always_comb begin
    case (cmd.wsel)
      WS_APPEND: begin
        wr_idx  = used_r;
        wr_data = val_r;
      end
      WS_PLACE: begin
        wr_idx  = pos_x[CNT_W-1:0];
        wr_data = val_r;
      end
      default: begin
        wr_idx  = j_r;
        wr_data = rd_data;
      end
    endcase
  end

  always_comb begin
    stat.op                 = op_r;
    stat.pos_above_used     = (pos_x > used_x);
    stat.pos_not_below_used = (pos_x >= used_x);
    stat.full               = (used_r >= CNT_W'(CAPACITY));
    stat.j_above_pos        = (j_x > pos_x);
    stat.next_below_used    = (j_plus < used_r);
    stat.j_below_used       = (j_r < used_r);
    stat.hit                = (rd_data == val_r);
    stat.out_free           = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      ent_r[wr_idx[IDX_W-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cmd) begin
      op_r  <= opcode_t'(in_opcode);
      pos_r <= in_position;
      val_r <= in_item_value[VAL_W-1:0];
    end
    if (cmd.j_load_used) begin
      j_r <= used_r;
    end else if (cmd.j_load_pos) begin
      j_r <= pos_x[CNT_W-1:0];
    end else if (cmd.j_load_zero) begin
      j_r <= '0;
    end else if (cmd.j_inc) begin
      j_r <= j_plus;
    end else if (cmd.j_dec) begin
      j_r <= j_minus;
    end
    if (cmd.load_cmd) begin
      status_r <= ST_OK;
      found_r  <= '0;
    end else begin
      if (cmd.set_status) begin
        status_r <= cmd.status;
      end
      if (cmd.set_found) begin
        found_r <= j_r[IDX_W-1:0];
      end
    end
    if (cmd.load_out) begin
      out_status_r <= status_r;
      out_found_r  <= FX_W'(found_r) & FX_W'({FOUND_W{1'b1}});
      out_count_r  <= COUNT_W'(CX_W'(used_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        used_r <= used_r + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        used_r <= used_r - CNT_W'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_found_r;
  assign out_entry_count    = out_count_r;

endmodule
